>>> design/gas_pkg.sv
// Shared types, constants and codes for the graph adjacency store.
package gas_pkg;

  // Payload widths fixed by the channel formats
  localparam int unsigned VertW    = 6;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Default vertex capacity of the store
  localparam int unsigned MaxVerticesDef = 32;

  // Configuration register reset values
  localparam logic [VertW-1:0] VcountReset = 6'd32;
  localparam logic             DirectedReset = 1'b0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERTEX_COUNT   = 2'd0,
    CFG_GRAPH_DIRECTED = 2'd1
  } gas_cfg_idx_e;

  // Input transaction opcodes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INS_RD = 7'b0000010,
    ST_INS_WR = 7'b0000100,
    ST_Q_LOAD = 7'b0001000,
    ST_Q_SCAN = 7'b0010000,
    ST_Q_DRAIN = 7'b0100000,
    ST_Q_FIN  = 7'b1000000
  } gas_state_e;

  // Memory strobes from the sequencer
  typedef struct packed {
    logic prow_rd;
    logic prow_wr;
    logic wt_rd;
    logic wt_wr;
  } gas_mem_ctl_t;

  // Per-neighbor facts handed to the merge unit
  typedef struct packed {
    logic directed;
    logic out_en;
    logic out_bit;
    logic in_bit;
    logic n_ne_va;
    logic n_le_cnt;
    logic n_lt_va;
  } gas_merge_req_t;

  // Merge unit decision
  typedef struct packed {
    logic hit;
    logic use_in;
  } gas_merge_res_t;

endpackage

>>> design/gas_ifs.sv
// Valid/ready channel interfaces: input items, results and register writes.
interface gas_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [gas_pkg::VertW-1:0]           vertex_a;
  logic [gas_pkg::VertW-1:0]           vertex_b;
  logic signed [gas_pkg::WeightW-1:0]  weight;

  modport source (output valid, action, vertex_a, vertex_b, weight, input ready);
  modport sink   (input valid, action, vertex_a, vertex_b, weight, output ready);
endinterface

interface gas_out_if;
  logic                                valid;
  logic                                ready;
  logic [gas_pkg::VertW-1:0]           neighbor;
  logic signed [gas_pkg::WeightW-1:0]  edge_weight_out;
  logic                                found;
  logic                                last;

  modport source (output valid, neighbor, edge_weight_out, found, last, input ready);
  modport sink   (input valid, neighbor, edge_weight_out, found, last, output ready);
endinterface

interface gas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gas_pkg::CfgIdxW-1:0]    index;
  logic [gas_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/gas_edge_mem.sv
// Edge storage: presence rows with row valid bits, and the weight memory.
module gas_edge_mem #(
  parameter int unsigned MAX_VERTICES = gas_pkg::MaxVerticesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gas_pkg::gas_mem_ctl_t             ctl_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   prow_addr_i,
  input  logic [MAX_VERTICES-1:0]           prow_wdata_i,
  output logic [MAX_VERTICES-1:0]           prow_rdata_o,
  input  logic [2*$clog2(MAX_VERTICES)-1:0] w_waddr_i,
  input  logic [gas_pkg::WeightW-1:0]       w_wdata_i,
  input  logic [2*$clog2(MAX_VERTICES)-1:0] w_raddr_a_i,
  input  logic [2*$clog2(MAX_VERTICES)-1:0] w_raddr_b_i,
  output logic [gas_pkg::WeightW-1:0]       w_rdata_a_o,
  output logic [gas_pkg::WeightW-1:0]       w_rdata_b_o
);

  localparam int unsigned IdxW    = $clog2(MAX_VERTICES);
  localparam int unsigned CellW   = 2 * IdxW;
  localparam int unsigned WDepth  = 1 << CellW;

  logic [MAX_VERTICES-1:0]     prow_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]     row_vld_q;
  logic [MAX_VERTICES-1:0]     prow_rd_q;
  logic                        prow_rvld_q;

  logic [gas_pkg::WeightW-1:0] w_mem [WDepth];
  logic [gas_pkg::WeightW-1:0] w_rd_a_q;
  logic [gas_pkg::WeightW-1:0] w_rd_b_q;

  // Row valid bits: a row never written reads as no edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ctl_i.prow_wr) begin
      row_vld_q[prow_addr_i] <= 1'b1;
    end
  end

  // Presence row memory, one row per source vertex
  always_ff @(posedge clk_i) begin
    if (ctl_i.prow_wr) begin
      prow_mem[prow_addr_i] <= prow_wdata_i;
    end
    if (ctl_i.prow_rd) begin
      prow_rd_q   <= prow_mem[prow_addr_i];
      prow_rvld_q <= row_vld_q[prow_addr_i];
    end
  end

  assign prow_rdata_o = prow_rvld_q ? prow_rd_q : '0;

  // Weight memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.wt_wr) begin
      w_mem[w_waddr_i] <= w_wdata_i;
    end
    if (ctl_i.wt_rd) begin
      w_rd_a_q <= w_mem[w_raddr_a_i];
      w_rd_b_q <= w_mem[w_raddr_b_i];
    end
  end

  assign w_rdata_a_o = w_rd_a_q;
  assign w_rdata_b_o = w_rd_b_q;

endmodule

>>> design/gas_merge.sv
// Shared per-neighbor compare unit: picks the in-edge, the out-edge or nothing.
module gas_merge (
  input  gas_pkg::gas_merge_req_t req_i,
  output gas_pkg::gas_merge_res_t res_o
);

  logic has_out;
  logic has_in;

  // Out-edge seen when enabled for this query; in-edge only when undirected
  assign has_out = req_i.out_en & req_i.out_bit;
  assign has_in  = ~req_i.directed & req_i.n_ne_va & req_i.n_le_cnt & req_i.in_bit;

  // In-edge wins below the queried vertex, or when there is no out-edge
  assign res_o.hit    = has_in | has_out;
  assign res_o.use_in = has_in & (req_i.n_lt_va | ~has_out);

endmodule

>>> design/gas_ctrl.sv
// Sequencer: insert read-modify-write, neighbor scan, result holding and output.
module gas_ctrl #(
  parameter int unsigned MAX_VERTICES = gas_pkg::MaxVerticesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_action_i,
  input  logic [gas_pkg::VertW-1:0]         in_va_i,
  input  logic [gas_pkg::VertW-1:0]         in_vb_i,
  input  logic [gas_pkg::WeightW-1:0]       in_weight_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gas_pkg::VertW-1:0]         out_nb_o,
  output logic [gas_pkg::WeightW-1:0]       out_w_o,
  output logic                              out_found_o,
  output logic                              out_last_o,
  // configuration
  input  logic [gas_pkg::VertW:0]           vcount_i,
  input  logic                              directed_i,
  // edge memory
  output gas_pkg::gas_mem_ctl_t             mem_ctl_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   prow_addr_o,
  output logic [MAX_VERTICES-1:0]           prow_wdata_o,
  input  logic [MAX_VERTICES-1:0]           prow_rdata_i,
  output logic [2*$clog2(MAX_VERTICES)-1:0] w_waddr_o,
  output logic [gas_pkg::WeightW-1:0]       w_wdata_o,
  output logic [2*$clog2(MAX_VERTICES)-1:0] w_raddr_a_o,
  output logic [2*$clog2(MAX_VERTICES)-1:0] w_raddr_b_o,
  input  logic [gas_pkg::WeightW-1:0]       w_rdata_a_i,
  input  logic [gas_pkg::WeightW-1:0]       w_rdata_b_i,
  // merge unit
  output gas_pkg::gas_merge_req_t           merge_req_o,
  input  gas_pkg::gas_merge_res_t           merge_res_i
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);
  localparam logic [gas_pkg::VertW:0] VMax   = (gas_pkg::VertW+1)'(MAX_VERTICES);
  localparam logic [IdxW-1:0]         NLast  = IdxW'(MAX_VERTICES - 1);

  gas_pkg::gas_state_e state_q, state_d;

  // item registers
  logic [gas_pkg::VertW-1:0]   va_q, vb_q;
  logic [gas_pkg::WeightW-1:0] wt_q;

  // scan registers
  logic [IdxW-1:0]             n_q, n_d;
  logic [IdxW-1:0]             eval_n_q, eval_n_d;
  logic                        eval_v_q, eval_v_d;
  logic                        first_q, first_d;
  logic [MAX_VERTICES-1:0]     out_row_q, out_row_d;

  // held result and output register
  logic                        pend_v_q, pend_v_d;
  logic [gas_pkg::VertW-1:0]   pend_nb_q;
  logic [gas_pkg::WeightW-1:0] pend_w_q;
  logic                        pend_load;
  logic                        out_v_q, out_v_d;
  logic [gas_pkg::VertW-1:0]   out_nb_q;
  logic [gas_pkg::WeightW-1:0] out_w_q;
  logic                        out_found_q, out_last_q;
  logic                        move_load, fin_load;

  logic                        accept;
  logic                        va_ok, vb_ok;
  logic [gas_pkg::VertW-1:0]   va_m1, vb_m1;
  logic [IdxW-1:0]             va0, vb0;
  logic [gas_pkg::VertW:0]     va7, n7;
  logic                        out_busy, hit_act, stall;
  logic [gas_pkg::WeightW-1:0] sel_w;

  assign accept = in_valid_i & in_ready_o;

  // range checks on the incoming vertices
  assign va_ok = (in_va_i != '0) && ({1'b0, in_va_i} <= VMax);
  assign vb_ok = (in_vb_i != '0) && ({1'b0, in_vb_i} <= VMax);

  // zero-based row and column indexes
  assign va_m1 = va_q - gas_pkg::VertW'(1);
  assign vb_m1 = vb_q - gas_pkg::VertW'(1);
  assign va0   = va_m1[IdxW-1:0];
  assign vb0   = vb_m1[IdxW-1:0];
  assign va7   = {1'b0, va_q};
  assign n7    = (gas_pkg::VertW+1)'(eval_n_q) + (gas_pkg::VertW+1)'(1);

  // facts for the neighbor under evaluation
  assign merge_req_o.directed = directed_i;
  assign merge_req_o.out_en   = directed_i | (va7 <= vcount_i);
  assign merge_req_o.out_bit  = out_row_q[eval_n_q];
  assign merge_req_o.in_bit   = prow_rdata_i[va0];
  assign merge_req_o.n_ne_va  = (n7 != va7);
  assign merge_req_o.n_le_cnt = (n7 <= vcount_i);
  assign merge_req_o.n_lt_va  = (n7 < va7);

  assign sel_w    = merge_res_i.use_in ? w_rdata_b_i : w_rdata_a_i;
  assign out_busy = out_v_q & ~out_ready_i;
  assign hit_act  = eval_v_q & merge_res_i.hit;
  assign stall    = hit_act & pend_v_q & out_busy;

  // memory addressing
  assign prow_wdata_o = prow_rdata_i | (MAX_VERTICES'(1) << vb0);
  assign w_waddr_o    = {va0, vb0};
  assign w_wdata_o    = wt_q;
  assign w_raddr_a_o  = {va0, n_q};
  assign w_raddr_b_o  = {n_q, va0};

  // sequencer
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    eval_n_d   = eval_n_q;
    eval_v_d   = eval_v_q;
    first_d    = first_q;
    out_row_d  = out_row_q;
    pend_v_d   = pend_v_q;
    pend_load  = 1'b0;
    move_load  = 1'b0;
    fin_load   = 1'b0;
    in_ready_o = 1'b0;
    mem_ctl_o  = '0;
    prow_addr_o = va0;

    // a found neighbor goes to the holding slot, pushing the older one out
    if (hit_act && !stall) begin
      pend_load = 1'b1;
      pend_v_d  = 1'b1;
      move_load = pend_v_q;
    end

    case (state_q)
      gas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_action_i == gas_pkg::ACT_INSERT) begin
            if (va_ok && vb_ok) begin
              state_d = gas_pkg::ST_INS_RD;
            end
          end else begin
            state_d = va_ok ? gas_pkg::ST_Q_LOAD : gas_pkg::ST_Q_FIN;
          end
        end
      end
      gas_pkg::ST_INS_RD: begin
        mem_ctl_o.prow_rd = 1'b1;
        state_d = gas_pkg::ST_INS_WR;
      end
      gas_pkg::ST_INS_WR: begin
        // first weight stays when the edge is already present
        if (!prow_rdata_i[vb0]) begin
          mem_ctl_o.prow_wr = 1'b1;
          mem_ctl_o.wt_wr   = 1'b1;
        end
        state_d = gas_pkg::ST_IDLE;
      end
      gas_pkg::ST_Q_LOAD: begin
        mem_ctl_o.prow_rd = 1'b1;
        n_d      = '0;
        first_d  = 1'b1;
        eval_v_d = 1'b0;
        state_d  = gas_pkg::ST_Q_SCAN;
      end
      gas_pkg::ST_Q_SCAN: begin
        if (first_q) begin
          out_row_d = prow_rdata_i;
          first_d   = 1'b0;
        end
        if (!stall) begin
          mem_ctl_o.prow_rd = 1'b1;
          mem_ctl_o.wt_rd   = 1'b1;
          prow_addr_o = n_q;
          eval_v_d = 1'b1;
          eval_n_d = n_q;
          if (n_q == NLast) begin
            state_d = gas_pkg::ST_Q_DRAIN;
          end else begin
            n_d = n_q + IdxW'(1);
          end
        end
      end
      gas_pkg::ST_Q_DRAIN: begin
        if (!stall) begin
          eval_v_d = 1'b0;
          state_d  = gas_pkg::ST_Q_FIN;
        end
      end
      gas_pkg::ST_Q_FIN: begin
        if (!out_busy) begin
          fin_load = 1'b1;
          pend_v_d = 1'b0;
          state_d  = gas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gas_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_v_d = (move_load | fin_load) ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gas_pkg::ST_IDLE;
      n_q      <= '0;
      eval_n_q <= '0;
      eval_v_q <= 1'b0;
      first_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      eval_n_q <= eval_n_d;
      eval_v_q <= eval_v_d;
      first_q  <= first_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q <= in_va_i;
      vb_q <= in_vb_i;
      wt_q <= in_weight_i;
    end
    out_row_q <= out_row_d;
    if (pend_load) begin
      pend_nb_q <= n7[gas_pkg::VertW-1:0];
      pend_w_q  <= sel_w;
    end
    if (move_load) begin
      out_nb_q    <= pend_nb_q;
      out_w_q     <= pend_w_q;
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else if (fin_load) begin
      out_nb_q    <= pend_v_q ? pend_nb_q : '0;
      out_w_q     <= pend_v_q ? pend_w_q : '0;
      out_found_q <= pend_v_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_nb_o    = out_nb_q;
  assign out_w_o     = out_w_q;
  assign out_found_o = out_found_q;
  assign out_last_o  = out_last_q;

endmodule

>>> design/graph_adjacency_store_unit.sv
// Top level of the weighted adjacency-matrix graph store.
//
//   channel  dir  payload                                        transaction when
//   in_i     in   action, vertex_a, vertex_b, weight             valid & ready
//   out_o    out  neighbor, edge_weight_out, found, last         valid & ready
//   cfg_i    in   index (0 vertex_count, 1 graph_directed), data valid & ready (ready=1)
//
// Insert: row read, then row and weight write.
// Query: row load, one vertex per cycle while the output does not stall, through the
// presence row read port and the two weight read ports, drain, final result.
// Reset clears the presence row valid bits at once; no clearing pass is needed.
// The block takes a new item while the last result still waits in the output register.
module graph_adjacency_store_unit #(
  parameter int unsigned MAX_VERTICES = gas_pkg::MaxVerticesDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  gas_in_if.sink     in_i,
  gas_out_if.source  out_o,
  gas_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);
  localparam logic [gas_pkg::VertW:0] VMax = (gas_pkg::VertW+1)'(MAX_VERTICES);

  logic [gas_pkg::VertW-1:0]   vcount_q;
  logic                        directed_q;
  logic [gas_pkg::VertW:0]     vcount_eff;

  gas_pkg::gas_mem_ctl_t       mem_ctl;
  gas_pkg::gas_merge_req_t     merge_req;
  gas_pkg::gas_merge_res_t     merge_res;
  logic [IdxW-1:0]             prow_addr;
  logic [MAX_VERTICES-1:0]     prow_wdata, prow_rdata;
  logic [2*IdxW-1:0]           w_waddr, w_raddr_a, w_raddr_b;
  logic [gas_pkg::WeightW-1:0] w_wdata, w_rdata_a, w_rdata_b;
  logic [gas_pkg::WeightW-1:0] out_w;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= gas_pkg::VcountReset;
      directed_q <= gas_pkg::DirectedReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gas_pkg::CFG_VERTEX_COUNT:   vcount_q   <= cfg_i.data[gas_pkg::VertW-1:0];
        gas_pkg::CFG_GRAPH_DIRECTED: directed_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // vertex count saturated at the store capacity
  assign vcount_eff = ({1'b0, vcount_q} > VMax) ? VMax : {1'b0, vcount_q};

  gas_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_action_i  (in_i.action),
    .in_va_i      (in_i.vertex_a),
    .in_vb_i      (in_i.vertex_b),
    .in_weight_i  (in_i.weight),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_nb_o     (out_o.neighbor),
    .out_w_o      (out_w),
    .out_found_o  (out_o.found),
    .out_last_o   (out_o.last),
    .vcount_i     (vcount_eff),
    .directed_i   (directed_q),
    .mem_ctl_o    (mem_ctl),
    .prow_addr_o  (prow_addr),
    .prow_wdata_o (prow_wdata),
    .prow_rdata_i (prow_rdata),
    .w_waddr_o    (w_waddr),
    .w_wdata_o    (w_wdata),
    .w_raddr_a_o  (w_raddr_a),
    .w_raddr_b_o  (w_raddr_b),
    .w_rdata_a_i  (w_rdata_a),
    .w_rdata_b_i  (w_rdata_b),
    .merge_req_o  (merge_req),
    .merge_res_i  (merge_res)
  );

  assign out_o.edge_weight_out = out_w;

  gas_merge u_merge (
    .req_i (merge_req),
    .res_o (merge_res)
  );

  gas_edge_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mem_ctl),
    .prow_addr_i  (prow_addr),
    .prow_wdata_i (prow_wdata),
    .prow_rdata_o (prow_rdata),
    .w_waddr_i    (w_waddr),
    .w_wdata_i    (w_wdata),
    .w_raddr_a_i  (w_raddr_a),
    .w_raddr_b_i  (w_raddr_b),
    .w_rdata_a_o  (w_rdata_a),
    .w_rdata_b_o  (w_rdata_b)
  );

endmodule

>>> design/gas_checker.sv
// Port-level assertions for the graph store, bound to the top level.
module gas_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_action_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [gas_pkg::VertW-1:0]          out_neighbor_i,
  input logic signed [gas_pkg::WeightW-1:0] out_weight_i,
  input logic                               out_found_i,
  input logic                               out_last_i
);

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_neighbor_i) && $stable(out_weight_i)
      && $stable(out_found_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // a query occupies the block for the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == gas_pkg::ACT_QUERY) |=> !in_ready_i)
    else $error("new item taken right after a query");

  // an empty result is zero and closes its query
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_last_i && (out_neighbor_i == '0)
      && (out_weight_i == '0))
    else $error("malformed empty result");

endmodule

bind graph_adjacency_store_unit gas_checker u_gas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_neighbor_i (out_o.neighbor),
  .out_weight_i   (out_o.edge_weight_out),
  .out_found_i    (out_o.found),
  .out_last_i     (out_o.last)
);

>>> tb/graph_adjacency_store_unit_tb.sv
// Self-checking testbench for the weighted adjacency-matrix graph store.
`timescale 1ns / 100ps

module graph_adjacency_store_unit_tb;

  localparam int unsigned MaxV      = gas_pkg::MaxVerticesDef;
  localparam int unsigned HoldCyc   = MaxV + 8;   // query scan plus pipeline slack
  localparam int unsigned StallLimit = 3000;      // cycles with no transaction at all
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseItems = 55;

  // One input transaction
  typedef struct packed {
    logic                               action;
    logic [gas_pkg::VertW-1:0]          vertex_a;
    logic [gas_pkg::VertW-1:0]          vertex_b;
    logic signed [gas_pkg::WeightW-1:0] weight;
  } edge_cmd_t;

  // One result transaction
  typedef struct packed {
    logic [gas_pkg::VertW-1:0]          neighbor;
    logic signed [gas_pkg::WeightW-1:0] weight;
    logic                               found;
    logic                               last;
  } nbr_res_t;

  // Directed stimulus row; typed rows carry their single result
  typedef struct {
    edge_cmd_t cmd;
    bit        typed;
    nbr_res_t  res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gas_in_if  item_ch ();
  gas_out_if result_ch ();
  gas_cfg_if reg_ch ();

  graph_adjacency_store_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (result_ch),
    .cfg_i  (reg_ch)
  );

  // Shadow copy of the edge store and registers
  bit                          adj_on [0:MaxV][0:MaxV];
  logic [gas_pkg::WeightW-1:0] adj_wt [0:MaxV][0:MaxV];
  logic [gas_pkg::VertW-1:0]   shadow_vcount   = gas_pkg::VcountReset;
  logic                        shadow_directed = gas_pkg::DirectedReset;

  nbr_res_t exp_neighbors [$];
  dir_row_t dir_rows [$];

  // Row override handed to the monitor along with the transaction
  bit       typed_q;
  nbr_res_t typed_res_q;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned fails = 0;
  int unsigned n_items = 0;
  int unsigned n_queries = 0;
  int unsigned n_results = 0;
  int unsigned n_found = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;

  // Per-phase register settings, address span and idling
  int unsigned ph_vcount [NumPhases] = '{32, 32, 1, 0, 63, 17, 5, 33};
  bit          ph_dir    [NumPhases] = '{0, 1, 0, 1, 0, 0, 0, 1};
  int unsigned ph_span   [NumPhases] = '{10, 10, 32, 8, 32, 20, 12, 32};
  int unsigned ph_txidle [NumPhases] = '{0, 74, 0, 33, 0, 74, 0, 33};
  int unsigned ph_rxstall[NumPhases] = '{0, 0, 74, 33, 0, 0, 74, 33};

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result-side backpressure
  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // First insert of an edge wins; out-of-range vertices are dropped
  function automatic void store_edge(logic [gas_pkg::VertW-1:0] va,
                                     logic [gas_pkg::VertW-1:0] vb,
                                     logic [gas_pkg::WeightW-1:0] w);
    if (va >= 1 && va <= MaxV && vb >= 1 && vb <= MaxV && !adj_on[va][vb]) begin
      adj_on[va][vb] = 1'b1;
      adj_wt[va][vb] = w;
    end
  endfunction

  // Neighbor list of one vertex, merged per the current mode
  function automatic void scan_neighbors(logic [gas_pkg::VertW-1:0] va);
    int unsigned cnt;
    bit          has_o;
    bit          has_i;
    nbr_res_t    hits [$];
    nbr_res_t    r;
    if (va >= 1 && va <= MaxV) begin
      cnt = (shadow_vcount > MaxV) ? MaxV : shadow_vcount;
      for (int n = 1; n <= MaxV; n++) begin
        has_o = (shadow_directed || va <= cnt) && adj_on[va][n];
        has_i = !shadow_directed && n != va && n <= cnt && adj_on[n][va];
        r = '{neighbor: gas_pkg::VertW'(n), weight: '0, found: 1'b1, last: 1'b0};
        if (has_i && (n < va || !has_o)) begin
          r.weight = adj_wt[n][va];
          hits = {hits, r};
        end else if (has_o) begin
          r.weight = adj_wt[va][n];
          hits = {hits, r};
        end
      end
    end
    if (hits.size() == 0) begin
      r = '{neighbor: '0, weight: '0, found: 1'b0, last: 1'b0};
      hits = {hits, r};
    end
    foreach (hits[i]) begin
      r = hits[i];
      r.last = (i == hits.size() - 1);
      exp_neighbors = {exp_neighbors, r};
    end
  endfunction

  // Monitor: register writes, accepted items, checked results, watchdog
  always @(posedge clk_i) begin : monitor
    nbr_res_t want;
    nbr_res_t got;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (reg_ch.valid && reg_ch.ready) begin
        moved = 1'b1;
        case (reg_ch.index)
          gas_pkg::CFG_VERTEX_COUNT:   shadow_vcount = reg_ch.data;
          gas_pkg::CFG_GRAPH_DIRECTED: shadow_directed = reg_ch.data[0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        moved = 1'b1;
        n_items++;
        if (item_ch.action == gas_pkg::ACT_INSERT) begin
          store_edge(item_ch.vertex_a, item_ch.vertex_b, item_ch.weight);
        end else begin
          n_queries++;
          if (typed_q) exp_neighbors = {exp_neighbors, typed_res_q};
          else scan_neighbors(item_ch.vertex_a);
        end
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        n_results++;
        got = '{neighbor: result_ch.neighbor, weight: result_ch.edge_weight_out,
                found: result_ch.found, last: result_ch.last};
        if (got.found) n_found++;
        if (exp_neighbors.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: nb=%0d w=%0d found=%0b last=%0b",
                     got.neighbor, got.weight, got.found, got.last);
        end else begin
          want = exp_neighbors.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch at %0t: exp nb=%0d w=%0d found=%0b last=%0b,",
                        " got nb=%0d w=%0d found=%0b last=%0b"},
                       $realtime, want.neighbor, want.weight, want.found, want.last,
                       got.neighbor, got.weight, got.found, got.last);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one item, with random leading idle cycles; valid stays high on exit
  task automatic send_item(input edge_cmd_t cmd, input bit typed, input nbr_res_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.action   <= cmd.action;
    item_ch.vertex_a <= cmd.vertex_a;
    item_ch.vertex_b <= cmd.vertex_b;
    item_ch.weight   <= cmd.weight;
    typed_q          <= typed;
    typed_res_q      <= res;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_neighbors.size() != 0) @(posedge clk_i);
  endtask

  // Both register writes; block must be idle
  task automatic set_config(input logic [gas_pkg::VertW-1:0] vc, input logic dir);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= gas_pkg::CFG_VERTEX_COUNT;
    reg_ch.data  <= vc;
    @(posedge clk_i);
    while (!reg_ch.ready) @(posedge clk_i);
    reg_ch.index <= gas_pkg::CFG_GRAPH_DIRECTED;
    reg_ch.data  <= {(gas_pkg::CfgDataW-1)'($urandom_range(31)), dir};
    @(posedge clk_i);
    while (!reg_ch.ready) @(posedge clk_i);
    reg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  function automatic dir_row_t row(logic act, int va, int vb, int w, bit typed,
                                   int nb, int wt, bit fnd);
    dir_row_t r;
    r.cmd   = '{action: act, vertex_a: gas_pkg::VertW'(va),
                vertex_b: gas_pkg::VertW'(vb), weight: gas_pkg::WeightW'(w)};
    r.typed = typed;
    r.res   = '{neighbor: gas_pkg::VertW'(nb), weight: gas_pkg::WeightW'(wt),
                found: fnd, last: 1'b1};
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Mostly in-span vertices; some zero and out-of-range ones
  function automatic logic [gas_pkg::VertW-1:0] pick_vertex(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 10) return gas_pkg::VertW'($urandom_range(63, MaxV + 1));
    return gas_pkg::VertW'($urandom_range(span, 1));
  endfunction

  initial begin : stimulus
    edge_cmd_t cmd;
    nbr_res_t  none;
    int unsigned roll;

    rst_ni           = 1'b0;
    item_ch.valid    = 1'b0;
    item_ch.action   = gas_pkg::ACT_INSERT;
    item_ch.vertex_a = '0;
    item_ch.vertex_b = '0;
    item_ch.weight   = '0;
    reg_ch.valid     = 1'b0;
    reg_ch.index     = gas_pkg::CFG_VERTEX_COUNT;
    reg_ch.data      = '0;
    result_ch.ready  = 1'b0;
    typed_q          = 1'b0;
    none             = '{neighbor: '0, weight: '0, found: 1'b0, last: 1'b1};
    typed_res_q      = none;

    // Directed table, default registers
    add_row(row(gas_pkg::ACT_QUERY, 5, 0, 0, 1, 0, 0, 0));          // empty store
    add_row(row(gas_pkg::ACT_QUERY, 0, 0, 0, 1, 0, 0, 0));          // vertex zero
    add_row(row(gas_pkg::ACT_QUERY, 63, 63, -1, 1, 0, 0, 0));       // vertex past range
    add_row(row(gas_pkg::ACT_INSERT, 1, 32, 32767, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 1, 0, 0, 1, 32, 32767, 1));
    add_row(row(gas_pkg::ACT_QUERY, 32, 0, 0, 1, 1, 32767, 1));     // in-edge merged
    add_row(row(gas_pkg::ACT_INSERT, 1, 32, 5, 0, 0, 0, 0));        // duplicate dropped
    add_row(row(gas_pkg::ACT_QUERY, 1, 0, 0, 1, 32, 32767, 1));
    add_row(row(gas_pkg::ACT_INSERT, 32, 32, -32768, 0, 0, 0, 0));  // self-loop
    add_row(row(gas_pkg::ACT_QUERY, 32, 0, 0, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 0, 5, 1, 0, 0, 0, 0));         // ignored inserts
    add_row(row(gas_pkg::ACT_INSERT, 5, 0, 1, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 33, 5, 1, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 5, 63, 1, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 5, 0, 0, 1, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 5, 3, 100, 0, 0, 0, 0));       // lower neighbor: in wins
    add_row(row(gas_pkg::ACT_INSERT, 3, 5, -200, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 5, 9, 7, 0, 0, 0, 0));         // upper neighbor: out wins
    add_row(row(gas_pkg::ACT_INSERT, 9, 5, 8, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 5, 0, 0, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 3, 0, 0, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 9, 0, 0, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 2, 31, 21845, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_INSERT, 31, 2, -21846, 0, 0, 0, 0));
    add_row(row(gas_pkg::ACT_QUERY, 31, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

    // Random phases, each with its own register setting and idling
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (HoldCyc) @(posedge clk_i);
      set_config(gas_pkg::VertW'(ph_vcount[p]), ph_dir[p]);
      tx_idle_pct  = ph_txidle[p];
      rx_stall_pct = ph_rxstall[p];
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(49) == 0) wait_drained();
        cmd.action   = ($urandom_range(99) < 35) ? gas_pkg::ACT_QUERY : gas_pkg::ACT_INSERT;
        cmd.vertex_a = pick_vertex(ph_span[p]);
        cmd.vertex_b = pick_vertex(ph_span[p]);
        roll = $urandom_range(99);
        if (roll < 4) cmd.weight = 16'sh7fff;
        else if (roll < 8) cmd.weight = 16'sh8000;
        else cmd.weight = gas_pkg::WeightW'($urandom());
        send_item(cmd, 1'b0, none);
      end
    end

    wait_drained();
    repeat (HoldCyc) @(posedge clk_i);
    fails += exp_neighbors.size();

    $display("Run covered %0d items (%0d queries) under %0d register settings",
             n_items, n_queries, n_settings);
    $display("plus reset defaults; %0d results checked, %0d carrying a neighbor, %0d failures.",
             n_results, n_found, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
